// ===== sv/crc16_ccitt_hex_trailer_unit_assert.svh =====
// Assertion macros for the CRC-16 hex trailer unit.
// No dependencies; included by crc16_ccitt_hex_trailer_unit, which carries assertions.
`ifndef CRC16_CCITT_HEX_TRAILER_UNIT_ASSERT_SVH
`define CRC16_CCITT_HEX_TRAILER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent holds in the same cycle as the antecedent
`define CRCHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Consequent holds in the cycle after the antecedent
`define CRCHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define CRCHT_ASSERT_NOW(label, clk, rst, ante, cons)
`define CRCHT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/crcht_pkg.sv =====
// Package for the CRC-16 hex trailer unit: nibble table, CRC and hex helpers.
// No dependencies; imported by crc16_ccitt_hex_trailer_unit.
package crcht_pkg;

   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [7:0]  SPACE_CHAR = 8'h20;
   localparam logic [7:0]  ASCII_ZERO = 8'h30;
   // 'A' minus ten, so that digit values 10..15 land on 'A'..'F'
   localparam logic [7:0]  ASCII_HEX_BASE = 8'h37;
   localparam logic [3:0]  DECIMAL_LIMIT  = 4'd10;

   // Trailer: one space word and four hex digit words
   localparam int unsigned TRAIL_WIDTH = 3;
   localparam logic [TRAIL_WIDTH-1:0] TRAIL_NONE   = 3'd0;
   localparam logic [TRAIL_WIDTH-1:0] TRAIL_SPACE  = 3'd5;
   localparam logic [TRAIL_WIDTH-1:0] TRAIL_DIGITS = 3'd4;
   localparam logic [TRAIL_WIDTH-1:0] TRAIL_FINAL  = 3'd1;

   localparam logic APPEND_RESET = 1'b1;

   localparam logic [15:0] NIBBLE_TAB [16] = '{
      16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
      16'h8108, 16'h9129, 16'hA14A, 16'hB16B, 16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
   };

   function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
      logic [3:0] idx;
      idx = crc[15:12] ^ nib;
      return NIBBLE_TAB[idx] ^ {crc[11:0], 4'h0};
   endfunction

   // Fold one byte, high nibble first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] mid;
      mid = crc_nibble(crc, b[7:4]);
      return crc_nibble(mid, b[3:0]);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] wide;
      wide = {4'h0, v};
      return (v < DECIMAL_LIMIT) ? (ASCII_ZERO + wide) : (ASCII_HEX_BASE + wide);
   endfunction

endpackage

// ===== sv/crc16_ccitt_hex_trailer_unit.sv =====
// Top level of the CRC-16 (poly 0x1021, init 0) byte echo unit with hex trailer.
// Depends on crcht_pkg and crc16_ccitt_hex_trailer_unit_assert.svh.
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+----------------------------------------
//  req_    | in  | req_valid / req_stall  | data_byte, end_of_message
//  rsp_    | out | rsp_valid / rsp_stall  | out_char, crc_value, last_of_run
//  csr_    | in  | csr_valid / csr_ready  | append_enable (ready always high)
//
//  One byte word is taken per unstalled cycle; its echo word is registered in the
//  next cycle. The byte CRC update (two table nibble steps) sits between the input
//  and the result register. A final byte with append on adds five trailer words
//  (space, then four hex digits, lowest nibble first), one per unstalled cycle; the
//  input stalls while they drain. Reset is synchronous and clears the CRC, the
//  trailer count and the result valid, and sets append on. A stalled result word
//  holds; the input is taken in the same cycle the held word leaves.
`include "crc16_ccitt_hex_trailer_unit_assert.svh"

module crc16_ccitt_hex_trailer_unit
   import crcht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic [15:0] rsp_crc_value,
   output logic        rsp_last_of_run,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_append_enable
);

   // Control state
   logic                   append_ff,    append_in;
   logic [15:0]            crc_ff,       crc_in;
   logic [TRAIL_WIDTH-1:0] trail_ff,     trail_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Result payload
   logic [7:0]             char_ff,      char_in;
   logic [15:0]            crc_out_ff,   crc_out_in;
   logic                   last_ff,      last_in;

   logic        out_free;
   logic        trail_busy;
   logic        req_accept;
   logic [15:0] byte_crc;
   logic [15:0] space_crc;
   logic [1:0]  digit_sel;
   logic [3:0]  digit_nib;

   // The result register can take a word when empty or when its word leaves now
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign trail_busy = (trail_ff != TRAIL_NONE);
   assign req_stall  = trail_busy || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign csr_ready  = 1'b1;

   assign byte_crc  = crc_byte(crc_ff, req_data_byte);
   assign space_crc = crc_byte(crc_ff, SPACE_CHAR);

   // Digit 0 goes out first, at trailer count four
   assign digit_sel = 2'(TRAIL_DIGITS - trail_ff);
   assign digit_nib = crc_ff[{digit_sel, 2'b00} +: 4];

   always_comb begin
      append_in    = append_ff;
      crc_in       = crc_ff;
      trail_in     = trail_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      crc_out_in   = crc_out_ff;
      last_in      = last_ff;

      if (csr_valid && csr_ready) begin
         append_in = csr_append_enable;
      end

      priority if (trail_busy && out_free) begin
         // Drain one trailer word: the space first, then the hex digits
         rsp_valid_in = 1'b1;
         trail_in     = trail_ff - TRAIL_FINAL;
         if (trail_ff == TRAIL_SPACE) begin
            char_in    = SPACE_CHAR;
            crc_in     = space_crc;
            crc_out_in = space_crc;
            last_in    = 1'b0;
         end else begin
            char_in    = hex_digit(digit_nib);
            crc_out_in = crc_ff;
            last_in    = (trail_ff == TRAIL_FINAL);
            if (trail_ff == TRAIL_FINAL) begin
               crc_in = '0;
            end
         end
      end else if (req_accept) begin
         // Echo the byte with the CRC after it
         rsp_valid_in = 1'b1;
         char_in      = req_data_byte;
         crc_out_in   = byte_crc;
         last_in      = req_end_of_message && !append_ff;
         crc_in       = byte_crc;
         if (req_end_of_message) begin
            if (append_ff) begin
               trail_in = TRAIL_SPACE;
            end else begin
               crc_in = '0;
            end
         end
      end else begin
         // Hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         append_ff    <= APPEND_RESET;
         crc_ff       <= '0;
         trail_ff     <= TRAIL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         append_ff    <= append_in;
         crc_ff       <= crc_in;
         trail_ff     <= trail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      crc_out_ff <= crc_out_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_crc_value   = crc_out_ff;
   assign rsp_last_of_run = last_ff;

   // A final byte with append on starts the trailer and is not itself the last word
   `CRCHT_ASSERT_NEXT(a_trail_start, clock, reset,
      req_accept && req_end_of_message && append_ff,
      trail_ff == TRAIL_SPACE && rsp_valid_ff && !last_ff)

   // The CRC is clear whenever the last word of a message is on show
   `CRCHT_ASSERT_NOW(a_crc_clear_at_last, clock, reset,
      rsp_valid_ff && last_ff, crc_ff == 16'h0000)

   // No last word while trailer words are still to come
   `CRCHT_ASSERT_NOW(a_no_early_last, clock, reset,
      rsp_valid_ff && trail_busy, !last_ff)

   // Trailer count stays within its span
   `CRCHT_ASSERT_NOW(a_trail_range, clock, reset,
      1'b1, trail_ff <= TRAIL_SPACE)

endmodule
